/* sv/framebuffer_rect_invert_defines.svh */
// ----------------------------------------------------------------------------
// framebuffer_rect_invert_defines.svh
// Assertion macros shared by the frame store RTL.
// ----------------------------------------------------------------------------
`ifndef FRAMEBUFFER_RECT_INVERT_DEFINES_SVH
`define FRAMEBUFFER_RECT_INVERT_DEFINES_SVH

`ifndef SYNTHESIS
// combinational implication checked at every edge outside reset
`define FBRI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// implication whose consequent is checked in the next cycle
`define FBRI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define FBRI_ASSERT_NOW(label, ante, cons, msg)
`define FBRI_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* sv/fbri_pkg.sv */
// ----------------------------------------------------------------------------
// fbri_pkg
// Geometry constants, widths and command codes of the frame store.
// ----------------------------------------------------------------------------
package fbri_pkg;

	localparam int SCREEN_WIDTH  = 128;
	localparam int SCREEN_HEIGHT = 64;
	localparam int WORD_W        = 32;
	localparam int BIT_SHIFT     = 5;
	localparam int LAST_BIT      = 31;
	localparam int WORDS_PER_ROW = (SCREEN_WIDTH + LAST_BIT) / WORD_W;
	localparam int STORE_DEPTH   = WORDS_PER_ROW * SCREEN_HEIGHT;
	localparam int ADDR_W        = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int Y_W           = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
	localparam int COL_W         = (WORDS_PER_ROW > 1) ? $clog2(WORDS_PER_ROW) : 1;
	localparam int CLIP_W        = 18;

	localparam logic [WORD_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

	localparam int IN_DATA_W  = 104;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 32;
	localparam int OUT_USER_W = 1;

	typedef enum logic [1:0] {
		OP_INVERT = 2'd0,
		OP_READ   = 2'd1,
		OP_WRITE  = 2'd2,
		OP_NOP    = 2'd3
	} opcode_t;

endpackage

/* sv/framebuffer_rect_invert.sv */
// ----------------------------------------------------------------------------
// framebuffer_rect_invert
// 1 bpp frame store with rectangle XOR invert and host word access.
// ----------------------------------------------------------------------------
// Commands enter on the s_ group (opcode in s_tuser, geometry, word index and
// write data in s_tdata); one result word leaves on the m_ group per command
// (read data in m_tdata, status in m_tuser).
// Invert: the CLIP state clips the rectangle, then the shared read-modify-write
// path walks the covered words row by row, one word per cycle (read issued
// while the previous word is written back through the RAM's second port).
// An invert steps through CLIP, RUN and DRAIN to DONE, an empty rectangle skips
// RUN and DRAIN, a read goes through HREAD, and a write or no-op goes straight
// to DONE. DONE posts the result when the output register is free, and s_tready
// returns in the same cycle as the result. The RAM read port sets the walk's pace.
// s_tready is high only while no command is in progress; the next command can
// be accepted while the previous result still waits in the output register.
// If m_tready stays low, a finished command holds until the output is free.
// Reset clears a valid bit per word, so the screen reads as all zero at once;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "framebuffer_rect_invert_defines.svh"

module framebuffer_rect_invert
	import fbri_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// rect_x, rect_y, rect_width, rect_height, word_index, write_word
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// opcode
	input  logic [IN_USER_W-1:0]  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// read_word
	output logic [OUT_DATA_W-1:0] m_tdata,
	// status
	output logic [OUT_USER_W-1:0] m_tuser
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_CLIP  = 6'b000010,
		ST_RUN   = 6'b000100,
		ST_DRAIN = 6'b001000,
		ST_HREAD = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t state_q;

	// input fields
	opcode_t            in_op;
	logic signed [15:0] in_x, in_y, in_w, in_h;
	logic [7:0]         in_index;
	logic [WORD_W-1:0]  in_wdata;
	logic               in_ok;
	logic               accept;

	assign in_op    = opcode_t'(s_tuser);
	assign in_x     = s_tdata[15:0];
	assign in_y     = s_tdata[31:16];
	assign in_w     = s_tdata[47:32];
	assign in_h     = s_tdata[63:48];
	assign in_index = s_tdata[71:64];
	assign in_wdata = s_tdata[103:72];
	assign in_ok    = int'(in_index) < STORE_DEPTH;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// latched rectangle
	logic signed [15:0] x_q, y_q, w_q, h_q;

	// walk state
	logic [Y_W-1:0]      row_q, row_last_q;
	logic [COL_W-1:0]    col_q, col_first_q, col_last_q;
	logic [BIT_SHIFT-1:0] first_bit_q, last_bit_q;

	// read-modify-write stage
	logic              act_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [WORD_W-1:0] mask_s1;
	logic              rd_valid_s1;

	// result holding
	logic [WORD_W-1:0] res_word_q;
	logic              res_status_q;
	logic              op_ok_q;

	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic                  m_tuser_q;
	logic                  m_tvalid_q;

	logic [STORE_DEPTH-1:0] valid_q;

	// RAM ports
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [WORD_W-1:0] ram_wdata, ram_rdata, ram_word;

	fbri_ram #(
		.WIDTH(WORD_W),
		.DEPTH(STORE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// never-written words read as zero
	assign ram_word = rd_valid_s1 ? ram_rdata : '0;

	// clipping
	logic signed [CLIP_W-1:0] x_end, y_end, x0c, x1c, y0c, y1c, x_lastc, y_lastc;
	logic                     clip_empty;

	always_comb begin
		x_end   = CLIP_W'(x_q) + CLIP_W'(w_q);
		y_end   = CLIP_W'(y_q) + CLIP_W'(h_q);
		x0c     = x_q[15] ? '0 : CLIP_W'(x_q);
		y0c     = y_q[15] ? '0 : CLIP_W'(y_q);
		x1c     = (x_end > CLIP_W'(SCREEN_WIDTH)) ? CLIP_W'(SCREEN_WIDTH) : x_end;
		y1c     = (y_end > CLIP_W'(SCREEN_HEIGHT)) ? CLIP_W'(SCREEN_HEIGHT) : y_end;
		x_lastc = x1c - CLIP_W'(1);
		y_lastc = y1c - CLIP_W'(1);
		clip_empty = w_q[15] || h_q[15] || (x1c <= x0c) || (y1c <= y0c);
	end

	// mask and address of the word being read
	logic [BIT_SHIFT-1:0] first_bit, last_bit;
	logic [WORD_W-1:0]    mask;
	logic [ADDR_W-1:0]    walk_addr;
	logic                 col_end, row_end;

	always_comb begin
		first_bit = (col_q == col_first_q) ? first_bit_q : '0;
		last_bit  = (col_q == col_last_q) ? last_bit_q : BIT_SHIFT'(LAST_BIT);
		mask      = (ALL_ONES >> first_bit) &
		            (ALL_ONES << (BIT_SHIFT'(LAST_BIT) - last_bit));
		walk_addr = ADDR_W'(int'(row_q) * WORDS_PER_ROW + int'(col_q));
		col_end   = (col_q == col_last_q);
		row_end   = (row_q == row_last_q);
	end

	always_comb begin
		if (accept) begin
			ram_raddr = ADDR_W'(in_index);
		end else begin
			ram_raddr = walk_addr;
		end
		if (act_s1) begin
			ram_we    = 1'b1;
			ram_waddr = addr_s1;
			ram_wdata = ram_word ^ mask_s1;
		end else begin
			ram_we    = accept && (in_op == OP_WRITE) && in_ok;
			ram_waddr = ADDR_W'(in_index);
			ram_wdata = in_wdata;
		end
	end

	// valid bits and read-side valid sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= valid_q[ram_raddr];
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			act_s1     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			act_s1 <= (state_q == ST_RUN);
			if ((state_q == ST_DONE) && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (in_op)
							OP_INVERT: state_q <= ST_CLIP;
							OP_READ:   state_q <= ST_HREAD;
							default:   state_q <= ST_DONE;
						endcase
					end
				end
				ST_CLIP: begin
					if (clip_empty) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (col_end && row_end) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_HREAD: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		addr_s1 <= walk_addr;
		mask_s1 <= mask;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					x_q          <= in_x;
					y_q          <= in_y;
					w_q          <= in_w;
					h_q          <= in_h;
					op_ok_q      <= in_ok;
					res_word_q   <= '0;
					res_status_q <= !((in_op == OP_WRITE) && in_ok);
				end
			end
			ST_CLIP: begin
				res_status_q <= clip_empty;
				row_q        <= Y_W'(y0c);
				row_last_q   <= Y_W'(y_lastc);
				col_q        <= COL_W'(x0c >>> BIT_SHIFT);
				col_first_q  <= COL_W'(x0c >>> BIT_SHIFT);
				col_last_q   <= COL_W'(x_lastc >>> BIT_SHIFT);
				first_bit_q  <= x0c[BIT_SHIFT-1:0];
				last_bit_q   <= x_lastc[BIT_SHIFT-1:0];
			end
			ST_RUN: begin
				if (col_end) begin
					col_q <= col_first_q;
					row_q <= row_q + Y_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
			ST_HREAD: begin
				res_word_q   <= op_ok_q ? ram_word : '0;
				res_status_q <= !op_ok_q;
			end
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					m_tdata_q <= res_word_q;
					m_tuser_q <= res_status_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	`FBRI_ASSERT_NEXT(a_run_feeds_rmw, state_q == ST_RUN, act_s1, "RUN cycle left no word in flight")
	`FBRI_ASSERT_NOW(a_no_accept_in_rmw, act_s1, !accept, "command accepted during write-back")
	`FBRI_ASSERT_NOW(a_done_drained, state_q == ST_DONE, !act_s1, "result with write-back pending")
	`FBRI_ASSERT_NOW(a_no_rw_collision, act_s1 && (state_q == ST_RUN), addr_s1 != walk_addr,
		"read and write-back hit the same word")

endmodule

/* sv/fbri_ram.sv */
// ----------------------------------------------------------------------------
// fbri_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fbri_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
